FILE: rtl/bhp_pkg.sv
`timescale 1ns / 1ps

package bhp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int BOND_W          = 20;
	// the largest normalized magnitude is brought into [2^(NORM_W-1), 2^NORM_W)
	localparam int NORM_W          = 30;

	typedef struct packed {
		logic valid;
		logic ok;
	} unit_stat_t;

endpackage

FILE: rtl/bhp_unitize.sv
`timescale 1ns / 1ps

module bhp_unitize #(
	parameter int VW    = 33,
	parameter int F     = 16,
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [2:0][VW-1:0]        v,
	input  logic [TAG_W-1:0]          tag_in,
	output bhp_pkg::unit_stat_t       stat,
	output logic [2:0][F+1:0]         u,
	output logic [TAG_W-1:0]          tag_out
);
	import bhp_pkg::*;

	localparam int PB    = $clog2(VW);
	localparam int NG    = (VW + 7) / 8;
	localparam int W2    = (VW > NORM_W) ? VW : NORM_W;
	localparam int SQ_W  = 2 * NORM_W;
	localparam int M2_W  = SQ_W + 2;
	localparam int ISQ_N = M2_W / 2;
	localparam int MAG_W = NORM_W + 1;
	localparam int NUM_W = NORM_W + 1 + F;
	localparam int DN    = F + 1;

	typedef struct packed {
		logic [2:0][NORM_W-1:0] mn;
		logic [2:0]             neg;
		logic                   zero;
		logic [TAG_W-1:0]       tag;
	} car_t;

	// stage 1: sign and magnitude
	logic [2:0][VW-1:0] m_s1;
	logic [2:0]         neg_s1;
	logic [VW-1:0]      or_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               v_s1;
	logic [2:0][VW-1:0] mag_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = v[i][VW-1] ? (~v[i] + VW'(1)) : v[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= mag_c;
			or_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			tag_s1 <= tag_in;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= v[i][VW-1];
			end
		end
	end

	// stage 2: leading one per byte group
	logic [2:0][VW-1:0] m_s2;
	logic [2:0]         neg_s2;
	logic [NG-1:0]      any_s2;
	logic [2:0]         pos_s2 [NG];
	logic [TAG_W-1:0]   tag_s2;
	logic               v_s2;
	logic [NG-1:0]      any_c;
	logic [2:0]         pos_c [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_c[g] = 1'b0;
			pos_c[g] = '0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < VW) begin
					if (or_s1[g * 8 + j]) begin
						any_c[g] = 1'b1;
						pos_c[g] = 3'(j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2   <= m_s1;
			neg_s2 <= neg_s1;
			any_s2 <= any_c;
			pos_s2 <= pos_c;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: pick top group, shift magnitudes into the normalized window
	car_t              car_s3;
	logic              v_s3;
	logic [PB-1:0]     p_c;
	logic [W2-1:0]     mext;
	logic [2:0][NORM_W-1:0] mn_c;

	always_comb begin
		p_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (any_s2[g]) begin
				p_c = PB'(g * 8 + int'(pos_s2[g]));
			end
		end
		mext = '0;
		for (int i = 0; i < 3; i++) begin
			mext = W2'(m_s2[i]);
			if (int'(p_c) >= NORM_W - 1) begin
				mn_c[i] = NORM_W'(mext >> (int'(p_c) - (NORM_W - 1)));
			end else begin
				mn_c[i] = NORM_W'(mext << ((NORM_W - 1) - int'(p_c)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s3.mn   <= mn_c;
			car_s3.neg  <= neg_s2;
			car_s3.zero <= ~|any_s2;
			car_s3.tag  <= tag_s2;
		end
	end

	// stage 4: squares
	logic [SQ_W-1:0] sq_s4 [3];
	car_t            car_s4;
	logic            v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(car_s3.mn[i]) * SQ_W'(car_s3.mn[i]);
			end
			car_s4 <= car_s3;
		end
	end

	// stage 5: sum of squares, then one root bit per stage
	logic [M2_W-1:0] rt_x_s   [ISQ_N+1];
	logic [M2_W-1:0] rt_r_s   [ISQ_N+1];
	car_t            rt_car_s [ISQ_N+1];
	logic            rt_v_s   [ISQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_x_s[0]   <= M2_W'(sq_s4[0]) + M2_W'(sq_s4[1]) + M2_W'(sq_s4[2]);
			rt_r_s[0]   <= '0;
			rt_car_s[0] <= car_s4;
		end
	end

	for (genvar k = 0; k < ISQ_N; k++) begin : g_rt
		localparam logic [M2_W-1:0] BITV = M2_W'(1) << (M2_W - 2 - 2 * k);
		logic [M2_W-1:0] trial;
		logic            take;

		assign trial = rt_r_s[k] + BITV;
		assign take  = rt_x_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_x_s[k+1]   <= take ? (rt_x_s[k] - trial) : rt_x_s[k];
				rt_r_s[k+1]   <= take ? ((rt_r_s[k] >> 1) + BITV) : (rt_r_s[k] >> 1);
				rt_car_s[k+1] <= rt_car_s[k];
			end
		end
	end

	// division setup: numerator with half-divisor rounding term
	logic [2:0][NUM_W-1:0] dv_num_s [DN+1];
	logic [2:0][MAG_W-1:0] dv_rem_s [DN+1];
	logic [2:0][F:0]       dv_q_s   [DN+1];
	logic [MAG_W-1:0]      dv_mag_s [DN+1];
	car_t                  dv_car_s [DN+1];
	logic                  dv_v_s   [DN+1];
	logic [MAG_W-1:0]      mag_c2;
	logic [2:0][NUM_W-1:0] num_c;

	assign mag_c2 = rt_r_s[ISQ_N][MAG_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NUM_W'(rt_car_s[ISQ_N].mn[i]) << F) + NUM_W'(mag_c2 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[ISQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_num_s[0] <= num_c;
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= MAG_W'(num_c[i] >> (F + 1));
			end
			dv_q_s[0]   <= '0;
			dv_mag_s[0] <= mag_c2;
			dv_car_s[0] <= rt_car_s[ISQ_N];
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DN; k++) begin : g_dv
		logic [2:0][MAG_W:0]   t;
		logic [2:0]            ge;
		logic [2:0][MAG_W-1:0] rem_n;
		logic [2:0][F:0]       q_n;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]     = {dv_rem_s[k][i], dv_num_s[k][i][F-k]};
				ge[i]    = t[i] >= {1'b0, dv_mag_s[k]};
				rem_n[i] = ge[i] ? MAG_W'(t[i] - {1'b0, dv_mag_s[k]}) : MAG_W'(t[i]);
				q_n[i]   = {dv_q_s[k][i][F-1:0], ge[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_num_s[k+1] <= dv_num_s[k];
				dv_rem_s[k+1] <= rem_n;
				dv_q_s[k+1]   <= q_n;
				dv_mag_s[k+1] <= dv_mag_s[k];
				dv_car_s[k+1] <= dv_car_s[k];
			end
		end
	end

	// sign restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat <= '0;
		end else if (en) begin
			stat.valid <= dv_v_s[DN];
			stat.ok    <= ~dv_car_s[DN].zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u[i] <= dv_car_s[DN].neg[i] ? ((F+2)'(0) - (F+2)'(dv_q_s[DN][i]))
					: (F+2)'(dv_q_s[DN][i]);
			end
			tag_out <= dv_car_s[DN].tag;
		end
	end

endmodule

FILE: rtl/bhp_place.sv
`timescale 1ns / 1ps

module bhp_place #(
	parameter int CW = 32,
	parameter int F  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][F+1:0]             ud,
	input  logic                          ok,
	input  logic [2:0][CW-1:0]            c,
	input  logic [bhp_pkg::BOND_W-1:0]    bl,
	input  logic                          last_in,
	output logic                          out_valid,
	output logic [2:0][CW-1:0]            site,
	output logic [2:0][F+1:0]             dir,
	output logic                          degenerate,
	output logic                          last_out
);
	import bhp_pkg::*;

	localparam int PR_W  = BOND_W + F + 1;
	localparam int OFF_W = PR_W + 1 - F;
	localparam int SW    = ((CW > OFF_W) ? CW : OFF_W) + 2;
	localparam logic signed [SW-1:0] HI = SW'({(CW-1){1'b1}});
	localparam logic signed [SW-1:0] LO = ~HI;

	// stage 1: offset magnitude product
	logic [PR_W-1:0]    prod_s1 [3];
	logic [2:0]         neg_s1;
	logic [2:0][F+1:0]  dv_s1;
	logic [2:0][CW-1:0] c_s1;
	logic               ok_s1, last_s1, v_s1;
	logic [2:0][F:0]    dm_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dm_c[i] = ud[i][F+1] ? (F+1)'((F+2)'(0) - ud[i]) : ud[i][F:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PR_W'(bl) * PR_W'(dm_c[i]);
				// direction is the negated bisector
				neg_s1[i]  <= ~ud[i][F+1] & (|ud[i]);
				dv_s1[i]   <= (F+2)'(0) - ud[i];
			end
			c_s1    <= c;
			ok_s1   <= ok;
			last_s1 <= last_in;
		end
	end

	// stage 2: round, add, saturate
	logic [OFF_W-1:0]       off_c [3];
	logic signed [SW-1:0]   cx_c  [3];
	logic signed [SW-1:0]   sm_c  [3];
	logic [2:0][CW-1:0]     sat_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_c[i] = OFF_W'(((PR_W+1)'(prod_s1[i]) + (PR_W+1)'(1 << (F - 1))) >> F);
			cx_c[i]  = {{(SW-CW){c_s1[i][CW-1]}}, c_s1[i]};
			sm_c[i]  = neg_s1[i] ? (cx_c[i] - SW'(off_c[i])) : (cx_c[i] + SW'(off_c[i]));
			if (sm_c[i] > HI) begin
				sat_c[i] = HI[CW-1:0];
			end else if (sm_c[i] < LO) begin
				sat_c[i] = LO[CW-1:0];
			end else begin
				sat_c[i] = sm_c[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			site       <= ok_s1 ? sat_c : '0;
			dir        <= ok_s1 ? dv_s1 : '0;
			degenerate <= ~ok_s1;
			last_out   <= last_s1;
		end
	end

endmodule

FILE: rtl/bisector_hydrogen_placement.sv
`timescale 1ns / 1ps

// Places a virtual amide hydrogen or carbonyl oxygen on the outer bisector
// of the two bonds at a central atom.
// Input stream s_*: one transfer per site with three atom positions and a
// bond length; s_tlast marks the last site of a batch. Output stream m_*:
// one transfer per input with the placed site, the unit direction and a
// degenerate flag in m_tuser; m_tlast copies the input marker.
// Throughput is one site per cycle unless m_tready stalls the output. The path
// holds two normalizers in series, each with a 31-stage square root and a
// FRAC_BITS+1 stage divider, one bit a stage.
// Every stage advances together; when m_tready is low with a result held,
// the whole pipeline freezes and s_tready drops in the same cycle, so no
// transfer is lost or repeated.
// Reset clears all valid bits; s_tready is high from the first cycle after
// reset release. Results for coincident atoms or cancelling bonds come out
// as zeros with m_tuser set.
module bisector_hydrogen_placement #(
	parameter int COORD_WIDTH = bhp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = bhp_pkg::FRAC_BITS_DEF,
	localparam int IN_BITS    = 9 * COORD_WIDTH + bhp_pkg::BOND_W,
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = 3 * COORD_WIDTH + 3 * (FRAC_BITS + 2),
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// prev_x, prev_y, prev_z, center_x, center_y, center_z,
	// following_x, following_y, following_z, bond_len
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tlast,   // last_site
	output logic             m_tvalid,
	input  logic             m_tready,
	// site_x, site_y, site_z, dir_x, dir_y, dir_z
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tuser,   // degenerate
	output logic             m_tlast    // last_out
);
	import bhp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int DW = F + 2;

	logic en;

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	// stage 1: bond vectors from the central atom
	logic [2:0][CW:0]   a_s1, b_s1;
	logic [2:0][CW-1:0] c_s1;
	logic [BOND_W-1:0]  bl_s1;
	logic               last_s1, v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= {s_tdata[i*CW+CW-1], s_tdata[i*CW +: CW]}
					- {s_tdata[(3+i)*CW+CW-1], s_tdata[(3+i)*CW +: CW]};
				b_s1[i] <= {s_tdata[(6+i)*CW+CW-1], s_tdata[(6+i)*CW +: CW]}
					- {s_tdata[(3+i)*CW+CW-1], s_tdata[(3+i)*CW +: CW]};
				c_s1[i] <= s_tdata[(3+i)*CW +: CW];
			end
			bl_s1   <= s_tdata[9*CW +: BOND_W];
			last_s1 <= s_tlast;
		end
	end

	// unit bond vectors; tags carry the side data past them
	unit_stat_t             stat_a, stat_b;
	logic [2:0][DW-1:0]     ua, ub;
	logic [BOND_W:0]        tag_a;
	logic [3*CW-1:0]        tag_b;

	bhp_unitize #(.VW(CW + 1), .F(F), .TAG_W(BOND_W + 1)) u_unit_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.v(a_s1), .tag_in({bl_s1, last_s1}),
		.stat(stat_a), .u(ua), .tag_out(tag_a)
	);

	bhp_unitize #(.VW(CW + 1), .F(F), .TAG_W(3 * CW)) u_unit_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.v(b_s1), .tag_in(c_s1),
		.stat(stat_b), .u(ub), .tag_out(tag_b)
	);

	// stage 2: bisector sum
	localparam int SUMW = F + 3;
	localparam int DTAG = 2 + BOND_W + 3 * CW;
	logic [2:0][SUMW-1:0] d_s2;
	logic [DTAG-1:0]      dtag_s2;
	logic                 v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= stat_a.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= {ua[i][DW-1], ua[i]} + {ub[i][DW-1], ub[i]};
			end
			dtag_s2 <= {stat_a.ok & stat_b.ok, tag_a, tag_b};
		end
	end

	unit_stat_t           stat_d;
	logic [2:0][DW-1:0]   ud;
	logic [DTAG-1:0]      tag_d;

	bhp_unitize #(.VW(SUMW), .F(F), .TAG_W(DTAG)) u_unit_d (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.v(d_s2), .tag_in(dtag_s2),
		.stat(stat_d), .u(ud), .tag_out(tag_d)
	);

	logic [2:0][CW-1:0] site;
	logic [2:0][DW-1:0] dir;

	bhp_place #(.CW(CW), .F(F)) u_place (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(stat_d.valid),
		.ud(ud), .ok(stat_d.ok & tag_d[DTAG-1]),
		.c(tag_d[3*CW-1:0]), .bl(tag_d[3*CW+1 +: BOND_W]), .last_in(tag_d[3*CW]),
		.out_valid(m_tvalid), .site(site), .dir(dir),
		.degenerate(m_tuser), .last_out(m_tlast)
	);

	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_BITS-1:0] = {dir[2], dir[1], dir[0], site[2], site[1], site[0]};
	end

	localparam logic signed [DW-1:0] DIR_MAX = DW'(1 << F);

	a_unit_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat_a.valid == stat_b.valid)
		else $error("bond normalizers out of step");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[OUT_BITS-1:0] == '0)
		else $error("degenerate result carries nonzero data");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			$signed(dir[0]) <= DIR_MAX && $signed(dir[0]) >= -DIR_MAX &&
			$signed(dir[1]) <= DIR_MAX && $signed(dir[1]) >= -DIR_MAX &&
			$signed(dir[2]) <= DIR_MAX && $signed(dir[2]) >= -DIR_MAX)
		else $error("direction component outside unit range");

endmodule

FILE: verif/bisector_hydrogen_placement_chk.sv
`timescale 1ns / 1ps

module bisector_hydrogen_placement_chk #(
	parameter int CW    = 32,
	parameter int FB    = 16,
	parameter int IN_W  = 312,
	parameter int OUT_W = 152
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tlast,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	input  logic             m_tuser,
	input  logic             m_tlast,
	output int               fail_cnt,
	output int               pending
);

	localparam int DW = FB + 2;

	typedef struct packed {
		logic [CW-1:0] sx, sy, sz;
		logic [DW-1:0] dx, dy, dz;
		logic          degen;
		logic          last;
	} site_t;

	site_t placed_q[$];

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= r + bit_v) begin
				x = x - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else
				r >>= 1;
			bit_v >>= 2;
		end
		return r;
	endfunction

	// returns 0 on a zero vector
	function automatic bit normalize(input longint v[3], output longint u[3]);
		longint unsigned m[3], mx, m2, mg, q;
		bit neg[3];
		mx = 0;
		m2 = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			m[i] = neg[i] ? -v[i] : v[i];
			if (m[i] > mx) mx = m[i];
		end
		for (int i = 0; i < 3; i++) u[i] = 0;
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < 3; i++) m2 += m[i] * m[i];
		mg = isqrt(m2);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (mg >> 1)) / mg;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic site_t place(logic [IN_W-1:0] d, logic lst);
		longint c[3], a[3], b[3], ua[3], ub[3], s[3], ud[3], dv, sv, hi, lo;
		longint unsigned dm, off, bl;
		bit ok;
		logic [CW-1:0] sites[3];
		logic [DW-1:0] dirs[3];
		site_t r;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		bl = d[9*CW +: 20];
		for (int i = 0; i < 3; i++) begin
			c[i] = $signed(d[(3+i)*CW +: CW]);
			a[i] = longint'($signed(d[i*CW +: CW])) - c[i];
			b[i] = longint'($signed(d[(6+i)*CW +: CW])) - c[i];
		end
		ok = normalize(a, ua);
		if (ok) ok = normalize(b, ub);
		if (ok) begin
			for (int i = 0; i < 3; i++) s[i] = ua[i] + ub[i];
			ok = normalize(s, ud);
		end
		for (int i = 0; i < 3; i++) begin
			sites[i] = '0;
			dirs[i] = '0;
			if (ok) begin
				dv = -ud[i];
				dm = dv < 0 ? -dv : dv;
				off = (bl * dm + (64'd1 << (FB - 1))) >> FB;
				sv = dv < 0 ? c[i] - longint'(off) : c[i] + longint'(off);
				if (sv > hi) sv = hi;
				if (sv < lo) sv = lo;
				sites[i] = sv[CW-1:0];
				dirs[i] = dv[DW-1:0];
			end
		end
		r.sx = sites[0]; r.sy = sites[1]; r.sz = sites[2];
		r.dx = dirs[0]; r.dy = dirs[1]; r.dz = dirs[2];
		r.degen = !ok;
		r.last = lst;
		return r;
	endfunction

	assign pending = placed_q.size();

	always @(posedge clk or negedge arst_n) begin
		site_t e;
		site_t got;
		if (!arst_n) begin
			fail_cnt <= 0;
		end else begin
			if (s_tvalid && s_tready)
				placed_q.push_back(place(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				got.sx = m_tdata[0 +: CW];
				got.sy = m_tdata[CW +: CW];
				got.sz = m_tdata[2*CW +: CW];
				got.dx = m_tdata[3*CW +: DW];
				got.dy = m_tdata[3*CW+DW +: DW];
				got.dz = m_tdata[3*CW+2*DW +: DW];
				got.degen = m_tuser;
				got.last = m_tlast;
				if (placed_q.size() == 0) begin
					$error("output transfer with no site expected");
					fail_cnt <= fail_cnt + 1;
				end else begin
					e = placed_q.pop_front();
					if (got != e) fail_cnt <= fail_cnt + 1;
					if (got.sx != e.sx) $error("site_x exp %h got %h", e.sx, got.sx);
					if (got.sy != e.sy) $error("site_y exp %h got %h", e.sy, got.sy);
					if (got.sz != e.sz) $error("site_z exp %h got %h", e.sz, got.sz);
					if (got.dx != e.dx) $error("dir_x exp %h got %h", e.dx, got.dx);
					if (got.dy != e.dy) $error("dir_y exp %h got %h", e.dy, got.dy);
					if (got.dz != e.dz) $error("dir_z exp %h got %h", e.dz, got.dz);
					if (got.degen != e.degen)
						$error("degenerate exp %b got %b", e.degen, got.degen);
					if (got.last != e.last)
						$error("last_out exp %b got %b", e.last, got.last);
				end
			end
		end
	end

endmodule

FILE: verif/bisector_hydrogen_placement_tb.sv
`timescale 1ns / 1ps

module bisector_hydrogen_placement_tb;

	localparam int CW    = 32;
	localparam int FB    = 16;
	localparam int IN_W  = ((9 * CW + 20 + 7) / 8) * 8;
	localparam int OUT_W = ((3 * CW + 3 * (FB + 2) + 7) / 8) * 8;
	localparam int LATENCY = 2 * FB + 82;
	localparam int N_RAND = 450;
	localparam int STALL_LIMIT = 20000;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser, m_tlast;
	logic [OUT_W-1:0] m_tdata;
	int fail_cnt, pending;
	bit quiet;        // no idling in the final stretch
	int idle_cnt;

	bisector_hydrogen_placement dut (.*);

	bisector_hydrogen_placement_chk #(.CW(CW), .FB(FB), .IN_W(IN_W), .OUT_W(OUT_W)) chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return {{CW{1'b0}}} | $urandom_range(0, 3) - 1;
			default: return CW'(int'($urandom_range(0, 20 << FB)) - (10 << FB));
		endcase
	endfunction

	// sender
	task automatic send_site(logic [CW-1:0] pr[3], logic [CW-1:0] ce[3],
		logic [CW-1:0] fo[3], logic [19:0] bl, logic lst);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {bl, fo[2], fo[1], fo[0], ce[2], ce[1], ce[0], pr[2], pr[1], pr[0]};
		s_tlast <= lst;
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_geom(logic [CW-1:0] pr[3], logic [CW-1:0] ce[3],
		logic [CW-1:0] fo[3], logic [19:0] bl);
		send_site(pr, ce, fo, bl, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [CW-1:0] p[3], c[3], f[3];
		logic [CW-1:0] mx, mn;
		int mode;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		quiet = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		p = '{1 << FB, 0, 0}; c = '{0, 0, 0}; f = '{0, 1 << FB, 0};
		send_geom(p, c, f, 20'h10000);
		send_geom(p, c, c, 20'h10000);            // next coincides with center
		send_geom(c, c, f, 20'hFFFFF);            // prev coincides with center
		f = '{-(1 << FB), 0, 0};
		send_geom(p, c, f, 20'h10000);            // bonds cancel
		p = '{mx, mx, mx}; c = '{mn, mn, mn}; f = '{mx, mn, mx};
		send_geom(p, c, f, 20'hFFFFF);
		send_geom(c, p, f, 20'hFFFFF);
		p = '{mn, mx, mn}; c = '{mx, mx, mx}; f = '{mn, mn, mn};
		send_geom(p, c, f, 20'hFFFFF);            // saturates
		c = '{mn, mn, mn};
		send_geom(f, c, p, 20'hFFFFF);
		p = '{1, 0, 0}; c = '{0, 0, 0}; f = '{0, 0, 1};
		send_geom(p, c, f, 20'h0);
		p = '{1, 2, 3}; f = '{3, 1, 2};
		send_site(p, c, f, 20'h1, 1);
		send_site(p, c, f, 20'h1, 0);
		// random
		for (int n = 0; n < N_RAND; n++) begin
			if (n > N_RAND - 60) quiet = 1;
			mode = $urandom_range(0, 9);
			mode = mode == 0 ? 0 : (mode == 1 ? 1 : 2);
			for (int i = 0; i < 3; i++) begin
				c[i] = rand_coord(mode);
				p[i] = (mode == 2) ? c[i] + rand_coord(2) / 8 : rand_coord(mode);
				f[i] = (mode == 2) ? c[i] + rand_coord(2) / 8 : rand_coord(mode);
			end
			if ($urandom_range(0, 19) == 0) p = c;
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < 3; i++) f[i] = 2 * c[i] - p[i];
			send_geom(p, c, f, 20'($urandom_range(0, 20'hFFFFF)));
		end
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver with one long hold-off early on
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		m_tready <= 0;
		repeat (300) @(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 6);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// watchdog on cycles with no transfer
	initial begin
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
